@@ rtl/bstk_pkg.sv @@
// Package for the bounded stack with bottom increment.
// Holds the shared constants, request and result types, and sequencer codes.
// No dependencies.
package bstk_pkg;

    localparam int DATA_W    = 32;
    localparam int CAP_W     = 11;
    localparam int VAL_W     = 16;
    localparam int RES_W     = 33;
    localparam int ADDR_W    = 3;
    localparam int DEPTH_DEF = 1024;

    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;
    localparam logic [RES_W-1:0] RES_EMPTY = '1;

    // register index is paddr[2]
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [1:0] {
        REQ_PUSH = 2'd0,
        REQ_POP  = 2'd1,
        REQ_INC  = 2'd2,
        REQ_NOP  = 2'd3
    } t_req_kind;

    typedef struct packed {
        t_req_kind          req_type;
        logic [VAL_W-1:0]   push_value;
        logic [VAL_W-1:0]   inc_count;
        logic [VAL_W-1:0]   inc_amount;
    } t_req;

    typedef struct packed {
        logic signed [RES_W-1:0] result_value;
        logic                    was_empty;
        logic                    push_dropped;
    } t_rsp;

    typedef enum logic [4:0] {
        S_IDLE      = 5'b00001,
        S_POP_SUM   = 5'b00010,
        S_POP_CARRY = 5'b00100,
        S_INC       = 5'b01000,
        S_RESP      = 5'b10000
    } t_state;

    typedef enum logic [1:0] {
        ALU_POP_SUM = 2'd0,
        ALU_CARRY   = 2'd1,
        ALU_INC     = 2'd2
    } t_alu_sel;

    typedef struct packed {
        t_alu_sel            sel;
        logic [DATA_W-1:0]   entry;
        logic [DATA_W-1:0]   pend;
        logic [DATA_W-1:0]   hold;
        logic [VAL_W-1:0]    amount;
    } t_alu_in;

endpackage

@@ rtl/bstk_ram.sv @@
// Single-port-write, single-port-read RAM with registered read data.
// Depends on bstk_pkg for default sizes.
module bstk_ram #(
    parameter int WIDTH = bstk_pkg::DATA_W,
    parameter int DEPTH = bstk_pkg::DEPTH_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/bstk_alu.sv @@
// Shared 32-bit adder with operand selection for pop, carry-down and increment.
// Depends on bstk_pkg.
module bstk_alu (
    input  bstk_pkg::t_alu_in          i_op,
    output logic [bstk_pkg::DATA_W-1:0] o_sum
);

    logic [bstk_pkg::DATA_W-1:0] w_a;
    logic [bstk_pkg::DATA_W-1:0] w_b;

    always_comb begin
        unique case (i_op.sel)
            bstk_pkg::ALU_POP_SUM: begin
                w_a = i_op.entry;
                w_b = i_op.pend;
            end
            bstk_pkg::ALU_CARRY: begin
                w_a = i_op.pend;
                w_b = i_op.hold;
            end
            bstk_pkg::ALU_INC: begin
                w_a = i_op.pend;
                w_b = {{(bstk_pkg::DATA_W - bstk_pkg::VAL_W){1'b0}}, i_op.amount};
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    assign o_sum = w_a + w_b;

endmodule

@@ rtl/bstk_ctrl.sv @@
// Request sequencer: fill level, entry and pending-add memories, output register.
// Pending add at index i applies to entries 0..i and is carried down on pop.
// Depends on bstk_pkg, bstk_ram, bstk_alu.
module bstk_ctrl #(
    parameter int DEPTH = bstk_pkg::DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [bstk_pkg::CAP_W-1:0]    i_capacity,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  bstk_pkg::t_req                i_req,
    output logic                          o_valid,
    input  logic                          i_ready,
    output bstk_pkg::t_rsp                o_rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);
    localparam int CW = (FW > bstk_pkg::CAP_W) ? FW : bstk_pkg::CAP_W;
    localparam int NW = (FW > bstk_pkg::VAL_W) ? FW : bstk_pkg::VAL_W;

    bstk_pkg::t_state r_state, n_state;
    logic [FW-1:0]    r_fill, n_fill;
    logic [AW-1:0]    r_addr, n_addr;
    logic [bstk_pkg::DATA_W-1:0] r_hold, n_hold;
    logic [bstk_pkg::VAL_W-1:0]  r_amount, n_amount;
    bstk_pkg::t_rsp   r_res, n_res;
    bstk_pkg::t_rsp   r_out;
    logic             r_out_valid;

    logic [CW-1:0]    w_cap;
    logic [CW-1:0]    w_depth;
    logic [CW-1:0]    w_limit;
    logic             w_full;
    logic [NW-1:0]    w_cnt;
    logic [NW-1:0]    w_fill_n;
    logic [NW-1:0]    w_n;
    logic [NW-1:0]    w_n_m1;
    logic [FW-1:0]    w_fill_m1;
    logic [AW-1:0]    w_top;
    logic [AW-1:0]    w_top_m1;
    logic             w_accept;
    logic             w_load_out;

    logic                        w_we_entry;
    logic                        w_we_pend;
    logic [AW-1:0]               w_waddr;
    logic [bstk_pkg::DATA_W-1:0] w_wdata_entry;
    logic [bstk_pkg::DATA_W-1:0] w_wdata_pend;
    logic [AW-1:0]               w_raddr;
    logic [bstk_pkg::DATA_W-1:0] w_entry_rd;
    logic [bstk_pkg::DATA_W-1:0] w_pend_rd;
    bstk_pkg::t_alu_sel          w_alu_sel;
    bstk_pkg::t_alu_in           w_alu_in;
    logic [bstk_pkg::DATA_W-1:0] w_sum;

    bstk_ram #(.WIDTH(bstk_pkg::DATA_W), .DEPTH(DEPTH)) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (w_we_entry),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata_entry),
        .i_raddr (w_raddr),
        .o_rdata (w_entry_rd)
    );

    bstk_ram #(.WIDTH(bstk_pkg::DATA_W), .DEPTH(DEPTH)) u_pend_ram (
        .i_clk   (i_clk),
        .i_we    (w_we_pend),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata_pend),
        .i_raddr (w_raddr),
        .o_rdata (w_pend_rd)
    );

    bstk_alu u_alu (
        .i_op  (w_alu_in),
        .o_sum (w_sum)
    );

    assign w_cap    = CW'(i_capacity);
    assign w_depth  = CW'(DEPTH);
    assign w_limit  = (w_cap < w_depth) ? w_cap : w_depth;
    assign w_full   = CW'(r_fill) >= w_limit;

    assign w_cnt    = NW'(i_req.inc_count);
    assign w_fill_n = NW'(r_fill);
    assign w_n      = (w_cnt < w_fill_n) ? w_cnt : w_fill_n;
    assign w_n_m1   = w_n - NW'(1);

    assign w_fill_m1 = r_fill - FW'(1);
    assign w_top     = w_fill_m1[AW-1:0];
    assign w_top_m1  = w_top - AW'(1);

    assign o_ready    = (r_state == bstk_pkg::S_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_load_out = (r_state == bstk_pkg::S_RESP) && (!r_out_valid || i_ready);

    assign w_alu_in.sel    = w_alu_sel;
    assign w_alu_in.entry  = w_entry_rd;
    assign w_alu_in.pend   = w_pend_rd;
    assign w_alu_in.hold   = r_hold;
    assign w_alu_in.amount = r_amount;
    assign w_wdata_entry   = {{(bstk_pkg::DATA_W - bstk_pkg::VAL_W){1'b0}}, i_req.push_value};

    always_comb begin
        n_state       = r_state;
        n_fill        = r_fill;
        n_addr        = r_addr;
        n_hold        = r_hold;
        n_amount      = r_amount;
        n_res         = r_res;
        w_we_entry    = 1'b0;
        w_we_pend     = 1'b0;
        w_waddr       = r_addr;
        w_wdata_pend  = w_sum;
        w_raddr       = r_addr;
        w_alu_sel     = bstk_pkg::ALU_POP_SUM;

        unique case (r_state)
            bstk_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_res    = '0;
                    n_amount = i_req.inc_amount;
                    n_state  = bstk_pkg::S_RESP;
                    unique case (i_req.req_type)
                        bstk_pkg::REQ_PUSH: begin
                            if (!w_full) begin
                                // new entry starts with no pending add
                                w_we_entry   = 1'b1;
                                w_we_pend    = 1'b1;
                                w_waddr      = r_fill[AW-1:0];
                                w_wdata_pend = '0;
                                n_fill       = r_fill + FW'(1);
                            end else begin
                                n_res.push_dropped = 1'b1;
                            end
                        end
                        bstk_pkg::REQ_POP: begin
                            if (r_fill == '0) begin
                                n_res.result_value = bstk_pkg::RES_EMPTY;
                                n_res.was_empty    = 1'b1;
                            end else begin
                                w_raddr = w_top;
                                n_addr  = w_top_m1;
                                n_fill  = w_fill_m1;
                                n_state = bstk_pkg::S_POP_SUM;
                            end
                        end
                        bstk_pkg::REQ_INC: begin
                            if (w_n != '0) begin
                                w_raddr = w_n_m1[AW-1:0];
                                n_addr  = w_n_m1[AW-1:0];
                                n_state = bstk_pkg::S_INC;
                            end
                        end
                        bstk_pkg::REQ_NOP: begin
                        end
                    endcase
                end
            end
            bstk_pkg::S_POP_SUM: begin
                w_alu_sel          = bstk_pkg::ALU_POP_SUM;
                n_res.result_value = {1'b0, w_sum};
                n_hold             = w_pend_rd;
                // carry the top's pending add onto the entry below, if any
                if (r_fill != '0) begin
                    w_raddr = r_addr;
                    n_state = bstk_pkg::S_POP_CARRY;
                end else begin
                    n_state = bstk_pkg::S_RESP;
                end
            end
            bstk_pkg::S_POP_CARRY: begin
                w_alu_sel    = bstk_pkg::ALU_CARRY;
                w_we_pend    = 1'b1;
                n_state      = bstk_pkg::S_RESP;
            end
            bstk_pkg::S_INC: begin
                w_alu_sel    = bstk_pkg::ALU_INC;
                w_we_pend    = 1'b1;
                n_state      = bstk_pkg::S_RESP;
            end
            bstk_pkg::S_RESP: begin
                if (!r_out_valid || i_ready) begin
                    n_state = bstk_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bstk_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bstk_pkg::S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_hold   <= n_hold;
        r_amount <= n_amount;
        r_res    <= n_res;
        if (w_load_out) begin
            r_out <= r_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(DEPTH))
        else $error("fill level above depth");

    a_push_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_req.req_type == bstk_pkg::REQ_PUSH && !w_full)
        |=> r_fill == $past(r_fill) + FW'(1))
        else $error("accepted push did not grow the stack");

    a_pop_shrink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_req.req_type == bstk_pkg::REQ_POP && r_fill != '0)
        |=> r_fill == $past(r_fill) - FW'(1))
        else $error("pop on a nonempty stack did not shrink it");

    a_resp_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out |=> (r_out_valid && r_state == bstk_pkg::S_IDLE))
        else $error("result not presented after completion");

endmodule

@@ rtl/bounded_stack_with_bottom_increment.sv @@
// Bounded stack with bottom increment: APB capacity register and request sequencer.
// Push, empty pop, no-op and zero-count increment go straight to the response state;
// increment updates the pending-add memory; pop adds the top's pending add and, if an entry
// remains, carries it down via the shared adder. One request at a time: the next is taken
// once the previous result is in the output register. Reset clears fill level to zero,
// capacity to 1024; memories are not cleared. Depends on bstk_pkg and bstk_ctrl.
module bounded_stack_with_bottom_increment #(
    parameter int DEPTH = bstk_pkg::DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bstk_pkg::ADDR_W-1:0]   paddr,
    input  logic [bstk_pkg::DATA_W-1:0]   pwdata,
    output logic [bstk_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  bstk_pkg::t_req                i_req,
    output logic                          o_valid,
    input  logic                          i_ready,
    output bstk_pkg::t_rsp                o_rsp
);

    logic [bstk_pkg::CAP_W-1:0] r_capacity;
    logic                       w_cap_sel;

    assign pready    = 1'b1;
    assign w_cap_sel = (paddr[bstk_pkg::ADDR_W-1] == bstk_pkg::REG_CAPACITY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= bstk_pkg::CAP_RESET;
        end else if (psel && penable && pwrite && w_cap_sel) begin
            r_capacity <= pwdata[bstk_pkg::CAP_W-1:0];
        end
    end

    assign prdata = w_cap_sel
        ? {{(bstk_pkg::DATA_W - bstk_pkg::CAP_W){1'b0}}, r_capacity} : '0;

    bstk_ctrl #(.DEPTH(DEPTH)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_capacity (r_capacity),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req      (i_req),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_rsp      (o_rsp)
    );

endmodule
